// ===== sv/u8u16_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder package
// Shared types, constants and the lead byte length function.
// ----------------------------------------------------------------------------
package u8u16_pkg;

    localparam int QueueDepth = 4;

    localparam logic [15:0] REPL_UNIT    = 16'hFFFD;
    localparam logic [15:0] SURR_HI_BASE = 16'hD800;
    localparam logic [15:0] SURR_LO_BASE = 16'hDC00;
    localparam logic [20:0] MAX_CP       = 21'h10FFFF;
    localparam logic [20:0] PLANE_OFFSET = 21'h010000;

    localparam logic [2:0] LEN_ONE   = 3'd1;
    localparam logic [2:0] LEN_TWO   = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR  = 3'd4;

    // One complete or cut-short sequence, first byte in the lowest bits.
    typedef struct packed {
        logic [31:0] bytes;
        logic [2:0]  len;
        logic        fin;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } push_t;

    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        if ((b & 8'hE0) == 8'hC0) begin
            len = LEN_TWO;
        end else if ((b & 8'hF0) == 8'hE0) begin
            len = LEN_THREE;
        end else if ((b & 8'hF8) == 8'hF0) begin
            len = LEN_FOUR;
        end else begin
            len = LEN_ONE;
        end
        return len;
    endfunction

endpackage

// ===== sv/u8u16_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Front end
// Accepts bytes, collects multi-byte sequences and hands finished or
// cut-short sequences to the job queue.
// ----------------------------------------------------------------------------
module u8u16_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // in_byte
    input  logic              s_tlast,   // final_byte
    input  logic              queue_full,
    output u8u16_pkg::push_t  push
);
    import u8u16_pkg::*;

    logic [23:0] held_reg, held_next;
    logic [1:0]  count_reg, count_next;
    logic [2:0]  seq_len_reg, seq_len_next;

    logic        accept;
    logic [2:0]  need;
    logic [2:0]  len;
    logic        hold;
    logic [31:0] bytes_all;

    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;

    assign need = (count_reg == 2'd0) ? lead_length(s_tdata) : seq_len_reg;
    assign len  = {1'b0, count_reg} + 3'd1;
    assign hold = !s_tlast && (need > len);

    always_comb begin
        case (count_reg)
            2'd0: bytes_all = {24'd0, s_tdata};
            2'd1: bytes_all = {16'd0, s_tdata, held_reg[7:0]};
            2'd2: bytes_all = {8'd0, s_tdata, held_reg[15:0]};
            default: bytes_all = {s_tdata, held_reg};
        endcase
    end

    always_comb begin
        push.valid     = accept && !hold;
        push.job.bytes = bytes_all;
        push.job.len   = len;
        push.job.fin   = s_tlast;
    end

    always_comb begin
        held_next    = held_reg;
        count_next   = count_reg;
        seq_len_next = seq_len_reg;
        if (accept) begin
            if (hold) begin
                held_next    = bytes_all[23:0];
                count_next   = count_reg + 2'd1;
                seq_len_next = need;
            end else begin
                held_next    = '0;
                count_next   = '0;
                seq_len_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg    <= '0;
            count_reg   <= '0;
            seq_len_reg <= '0;
        end else begin
            held_reg    <= held_next;
            count_reg   <= count_next;
            seq_len_reg <= seq_len_next;
        end
    end

endmodule

// ===== sv/u8u16_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Job queue
// Short first-in first-out store of sequences between front and back end.
// ----------------------------------------------------------------------------
module u8u16_queue #(
    parameter int DEPTH = u8u16_pkg::QueueDepth
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  u8u16_pkg::push_t  push,
    output logic              full,
    input  logic              pop,
    output u8u16_pkg::job_t   head,
    output logic              empty
);
    import u8u16_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    job_t            store_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            do_push, do_pop;

    assign full    = (count_reg == CntW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = store_reg[rd_ptr_reg];
    assign do_push = push.valid && !full;
    assign do_pop  = pop && !empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            store_reg[wr_ptr_reg] <= push.job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== sv/u8u16_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Back end
// Decodes the sequence at the queue head into UTF-16 code units and sends
// them out one beat at a time through an output register.
// ----------------------------------------------------------------------------
module u8u16_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  u8u16_pkg::job_t  head_job,
    input  logic             queue_empty,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [15:0]      m_tdata,   // code_unit
    output logic             m_tlast,   // run_last
    output logic             m_tuser    // stream_done
);
    import u8u16_pkg::*;

    function automatic logic [15:0] single_unit(input logic [7:0] b);
        return b[7] ? REPL_UNIT : {8'd0, b};
    endfunction

    logic [7:0]  b0, b1, b2, b3;
    logic [2:0]  need0;
    logic [20:0] cp;
    logic [19:0] offset;
    logic [2:0]  rest_len;
    logic [15:0] unit0, unit1, unit2;
    logic [1:0]  unit_cnt;
    logic [15:0] unit_sel;
    logic        last_unit;
    logic        load;

    logic [1:0]  idx_reg, idx_next;
    logic        valid_reg, valid_next;
    logic [15:0] data_reg;
    logic        last_reg;
    logic        done_reg;

    assign b0 = head_job.bytes[7:0];
    assign b1 = head_job.bytes[15:8];
    assign b2 = head_job.bytes[23:16];
    assign b3 = head_job.bytes[31:24];

    assign need0    = lead_length(b0);
    assign offset   = 20'(cp - PLANE_OFFSET);
    assign rest_len = head_job.len - 3'd1;

    always_comb begin
        case (need0)
            LEN_TWO:   cp = {10'd0, b0[4:0], b1[5:0]};
            LEN_THREE: cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
            LEN_FOUR:  cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
            default:   cp = {13'd0, b0};
        endcase
    end

    always_comb begin
        unit0    = REPL_UNIT;
        unit1    = REPL_UNIT;
        unit2    = REPL_UNIT;
        unit_cnt = 2'd1;
        if (!b0[7]) begin
            unit0 = {8'd0, b0};
        end else if (need0 == LEN_ONE) begin
            unit0 = REPL_UNIT;
        end else if (head_job.len == need0) begin
            if (cp > MAX_CP) begin
                unit0 = REPL_UNIT;
            end else if (cp[20:16] != 5'd0) begin
                unit0    = SURR_HI_BASE + {6'd0, offset[19:10]};
                unit1    = SURR_LO_BASE + {6'd0, offset[9:0]};
                unit_cnt = 2'd2;
            end else begin
                unit0 = cp[15:0];
            end
        end else begin
            // Stream ended inside a sequence: the lead byte is replaced and
            // the bytes behind it are decoded on their own.
            unit0 = REPL_UNIT;
            case (rest_len)
                3'd0: begin
                    unit_cnt = 2'd1;
                end
                3'd1: begin
                    unit1    = single_unit(b1);
                    unit_cnt = 2'd2;
                end
                default: begin
                    if (lead_length(b1) == LEN_TWO) begin
                        unit1    = {5'd0, b1[4:0], b2[5:0]};
                        unit_cnt = 2'd2;
                    end else begin
                        unit1    = single_unit(b1);
                        unit2    = single_unit(b2);
                        unit_cnt = 2'd3;
                    end
                end
            endcase
        end
    end

    always_comb begin
        case (idx_reg)
            2'd0:    unit_sel = unit0;
            2'd1:    unit_sel = unit1;
            default: unit_sel = unit2;
        endcase
    end

    assign last_unit = (idx_reg == (unit_cnt - 2'd1));
    assign load      = (!valid_reg || m_tready) && !queue_empty;
    assign pop       = load && last_unit;

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load) begin
            idx_next   = last_unit ? 2'd0 : idx_reg + 2'd1;
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= unit_sel;
            last_reg <= last_unit;
            done_reg <= last_unit && head_job.fin;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = done_reg;

endmodule

// ===== sv/utf8_to_utf16_decoder.sv =====
`timescale 1ns / 1ps
// A byte's finished sequence passes through the job queue and then the output register to m_tdata.
// Input takes one byte per cycle while the job queue is not full; the output register sends one
// code unit per cycle while m_tready is high, so a surrogate pair or an end-of-stream flush of
// up to three units goes out unit by unit. The job queue between front and back end absorbs such bursts.
// Reset (aresetn low, synchronous) drops any held partial sequence and all queued sequences.
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder
// Streaming transcoder from UTF-8 bytes to UTF-16 code units.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder #(
    parameter int QUEUE_DEPTH = u8u16_pkg::QueueDepth
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // final_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] code_unit
    output logic        m_tlast,   // run_last
    output logic        m_tuser    // [0] stream_done
);
    import u8u16_pkg::*;

    push_t push;
    job_t  head_job;
    logic  queue_full;
    logic  queue_empty;
    logic  pop;

    u8u16_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .queue_full (queue_full),
        .push       (push)
    );

    u8u16_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .full    (queue_full),
        .pop     (pop),
        .head    (head_job),
        .empty   (queue_empty)
    );

    u8u16_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head_job    (head_job),
        .queue_empty (queue_empty),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

endmodule

// ===== tb/sv/tb_utf8_to_utf16_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder testbench
// Streams UTF-8 bytes into the decoder and predicts every UTF-16 code unit,
// including surrogate pairs, replacement units and the flush of a sequence
// cut short by the end of the stream. Each code unit leaving the block is
// checked field by field against the oldest prediction. Both sides stall at
// random, with one long output stall that backs the block up.
// ----------------------------------------------------------------------------
module tb_utf8_to_utf16_decoder;
    import u8u16_pkg::*;

    typedef struct {
        logic [7:0] data;
        bit         fin;
    } utf8_byte_t;

    typedef struct {
        logic [15:0] unit;
        bit          run_last;
        bit          done;
    } utf16_unit_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;  // [7:0] in_byte
    logic        s_tlast  = 1'b0;   // final_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // [15:0] code_unit
    logic        m_tlast;           // run_last
    logic        m_tuser;           // [0] stream_done

    utf8_byte_t  pending_bytes[$];
    utf16_unit_t expected_units[$];
    utf16_unit_t unit_ref;

    // Partial sequence held by the predictor, first byte at index 0.
    logic [7:0]  held_seq[3];
    int          held_cnt = 0;

    int          accepted_beats = 0;
    int          offer_mark = 0;
    int          errors = 0;
    int          sink_hold = 0;
    bit          sink_hold_done = 1'b0;
    bit          calm;

    utf8_to_utf16_decoder uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #6 aclk = ~aclk;

    // Neither side idles while this window of beats passes.
    assign calm = (accepted_beats >= 120) && (accepted_beats < 220);

    function automatic int seq_len_of(logic [7:0] b);
        casez (b)
            8'b110?????: return 2;
            8'b1110????: return 3;
            8'b11110???: return 4;
            default:     return 1;
        endcase
    endfunction

    // Works out the code units caused by one accepted byte.
    task automatic predict_units(input logic [7:0] b, input bit fin);
        logic [7:0]  seq[4];
        logic [15:0] units[3];
        logic [20:0] cp;
        logic [20:0] off;
        int          len;
        int          i;
        int          n;
        utf16_unit_t u;
        for (int k = 0; k < held_cnt; k++) begin
            seq[k] = held_seq[k];
        end
        len = held_cnt;
        seq[len] = b;
        len++;
        if (!fin && seq_len_of(seq[0]) > len) begin
            for (int k = 0; k < len; k++) begin
                held_seq[k] = seq[k];
            end
            held_cnt = len;
            return;
        end
        // A complete sequence, or the end of the stream: everything held is
        // decoded as if it were the whole remaining input.
        i = 0;
        n = 0;
        while (i < len) begin
            if (seq[i] < 8'h80) begin
                cp = 21'(seq[i]);
                i += 1;
            end else if (seq_len_of(seq[i]) == 2 && i + 1 < len) begin
                cp = 21'({seq[i][4:0], seq[i+1][5:0]});
                i += 2;
            end else if (seq_len_of(seq[i]) == 3 && i + 2 < len) begin
                cp = 21'({seq[i][3:0], seq[i+1][5:0], seq[i+2][5:0]});
                i += 3;
            end else if (seq_len_of(seq[i]) == 4 && i + 3 < len) begin
                cp = {seq[i][2:0], seq[i+1][5:0], seq[i+2][5:0], seq[i+3][5:0]};
                i += 4;
            end else begin
                cp = 21'(REPL_UNIT);
                i += 1;
            end
            if (cp > MAX_CP) begin
                cp = 21'(REPL_UNIT);
            end
            if (cp > 21'h00FFFF) begin
                off = cp - PLANE_OFFSET;
                if (n < 3) begin
                    units[n] = SURR_HI_BASE + 16'(off[19:10]);
                    n++;
                end
                if (n < 3) begin
                    units[n] = SURR_LO_BASE + 16'(off[9:0]);
                    n++;
                end
            end else if (n < 3) begin
                units[n] = cp[15:0];
                n++;
            end
        end
        held_cnt = 0;
        for (int k = 0; k < n; k++) begin
            u.unit = units[k];
            u.run_last = (k == n - 1);
            u.done = (k == n - 1) && fin;
            expected_units.push_back(u);
        end
    endtask

    task automatic queue_byte(input logic [7:0] b, input bit fin);
        utf8_byte_t item;
        item.data = b;
        item.fin = fin;
        pending_bytes.push_back(item);
    endtask

    function automatic logic [7:0] lead_for(int n);
        case (n)
            1:       return 8'($urandom_range(8'h00, 8'h7F));
            2:       return 8'($urandom_range(8'hC0, 8'hDF));
            3:       return 8'($urandom_range(8'hE0, 8'hEF));
            default: return 8'($urandom_range(8'hF0, 8'hF7));
        endcase
    endfunction

    function automatic logic [7:0] cont_byte(bit any);
        if (any) begin
            return 8'($urandom_range(0, 255));
        end
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    // Input side: a beat offered stays put until it is taken.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && accepted_beats == offer_mark) begin
            s_tvalid <= 1'b1;
        end else if (pending_bytes.size() > 0 && (calm || $urandom_range(99) >= 24)) begin
            s_tvalid <= 1'b1;
            s_tdata <= pending_bytes[0].data;
            s_tlast <= pending_bytes[0].fin;
            offer_mark <= accepted_beats;
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            void'(pending_bytes.pop_front());
            predict_units(s_tdata, s_tlast);
            accepted_beats <= accepted_beats + 1;
        end
    end

    // Output side, with one long hold-off once the stream is well under way.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (sink_hold > 0) begin
            m_tready <= 1'b0;
            sink_hold <= sink_hold - 1;
        end else if (!sink_hold_done && accepted_beats >= 300) begin
            m_tready <= 1'b0;
            sink_hold <= 150;
            sink_hold_done <= 1'b1;
        end else begin
            m_tready <= calm || ($urandom_range(99) >= 24);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_units.size() == 0) begin
                $display("%0t: unexpected code unit: expected none, actual %h last %b done %b",
                         $time, m_tdata, m_tlast, m_tuser);
                errors++;
            end else begin
                unit_ref = expected_units.pop_front();
                if (m_tdata !== unit_ref.unit) begin
                    $display("%0t: code_unit mismatch: expected %h, actual %h",
                             $time, unit_ref.unit, m_tdata);
                    errors++;
                end
                if (m_tlast !== unit_ref.run_last) begin
                    $display("%0t: run_last mismatch: expected %b, actual %b",
                             $time, unit_ref.run_last, m_tlast);
                    errors++;
                end
                if (m_tuser !== unit_ref.done) begin
                    $display("%0t: stream_done mismatch: expected %b, actual %b",
                             $time, unit_ref.done, m_tuser);
                    errors++;
                end
            end
        end
    end

    initial begin
        int   random_items;
        int   kind;
        int   seq_n;
        int   cut;
        bit   stop;
        random_items = 0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // ASCII extremes and stray bytes.
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h7F, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'hFF, 1'b0);
        // Two, three and four byte forms, the last giving a surrogate pair.
        queue_byte(8'hC3, 1'b0);
        queue_byte(8'hA9, 1'b0);
        queue_byte(8'hE2, 1'b0);
        queue_byte(8'h82, 1'b0);
        queue_byte(8'hAC, 1'b0);
        queue_byte(8'hF0, 1'b0);
        queue_byte(8'h9F, 1'b0);
        queue_byte(8'h98, 1'b0);
        queue_byte(8'h80, 1'b0);
        // Code point beyond the Unicode range.
        queue_byte(8'hF4, 1'b0);
        queue_byte(8'h90, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'h80, 1'b0);
        // A follower that is not a continuation byte is still consumed.
        queue_byte(8'hC3, 1'b0);
        queue_byte(8'h41, 1'b0);
        queue_byte(8'h41, 1'b1);
        // End of stream inside a sequence: the held bytes are decoded again.
        queue_byte(8'hF0, 1'b0);
        queue_byte(8'hE2, 1'b0);
        queue_byte(8'h41, 1'b1);
        // A lead byte that is itself the last byte.
        queue_byte(8'hE2, 1'b1);

        // Let the block drain completely before the random part starts.
        wait (pending_bytes.size() == 0 && expected_units.size() == 0);

        while (random_items < 450) begin
            kind = $urandom_range(99);
            if (kind < 60) begin
                seq_n = $urandom_range(1, 4);
                stop = ($urandom_range(9) == 0);
                queue_byte(lead_for(seq_n), stop && seq_n == 1);
                for (int k = 1; k < seq_n; k++) begin
                    queue_byte(cont_byte(1'b0), stop && k == seq_n - 1);
                end
                random_items += seq_n;
            end else if (kind < 80) begin
                // Sequence cut short, often by the end of the stream.
                seq_n = $urandom_range(2, 4);
                cut = $urandom_range(1, seq_n - 1);
                stop = ($urandom_range(2) == 0);
                queue_byte(lead_for(seq_n), stop && cut == 1);
                for (int k = 1; k < cut; k++) begin
                    queue_byte(cont_byte($urandom_range(2) == 0), stop && k == cut - 1);
                end
                random_items += cut;
            end else begin
                queue_byte(8'($urandom_range(0, 255)), $urandom_range(9) == 0);
                random_items++;
            end
        end
        queue_byte(8'h2E, 1'b1);

        wait (pending_bytes.size() == 0 && expected_units.size() == 0);
        repeat (10) @(posedge aclk);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
